// File: src/cbsit_pkg.sv
// ----------------------------------------------------------------------------
// cbsit_pkg
// Codes, widths and reset values shared by the cartridge bank switch and
// IRQ timer block.
// ----------------------------------------------------------------------------
package cbsit_pkg;

  // Item function codes.
  typedef logic [1:0] func_t;
  localparam func_t FUNC_WRITE    = 2'd0;
  localparam func_t FUNC_TICK     = 2'd1;
  localparam func_t FUNC_PRG_LOOK = 2'd2;
  localparam func_t FUNC_CHR_LOOK = 2'd3;

  // Mapper register select, taken from address bits 14..12 of a write
  // with bits 15 and 11 set.
  typedef logic [2:0] reg_sel_t;
  localparam reg_sel_t SEL_CHR0    = 3'd0;
  localparam reg_sel_t SEL_CHR1    = 3'd1;
  localparam reg_sel_t SEL_CHR2    = 3'd2;
  localparam reg_sel_t SEL_CHR3    = 3'd3;
  localparam reg_sel_t SEL_COUNTER = 3'd4;
  localparam reg_sel_t SEL_ENABLE  = 3'd5;
  localparam reg_sel_t SEL_MIRROR  = 3'd6;
  localparam reg_sel_t SEL_PRG     = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_RAM_PRESENT    = 1'b1;

  // Field and bank widths.
  localparam int CHR_BANK_KB  = 2;
  localparam int CHR_OFS_W    = $clog2(CHR_BANK_KB * 1024);
  localparam int CHR_BANK_W   = 6;
  localparam int PRG_BANK_W   = 4;
  localparam int PRG_OFS_W    = 14;
  localparam int ROM_OFS_W    = PRG_BANK_W + PRG_OFS_W;
  localparam int COUNT_W      = 16;

  typedef logic [CHR_BANK_W-1:0] chr_bank_t;
  typedef logic [ROM_OFS_W-1:0]  rom_ofs_t;

  localparam logic [4:0] PRG_BANK_COUNT_RESET = 5'd16;

  // Mirroring modes.
  typedef logic [1:0] mirror_t;
  localparam mirror_t MIRROR_VERTICAL = 2'd0;

endpackage

// File: src/cartridge_bank_switch_irq_timer.sv
// ----------------------------------------------------------------------------
// cartridge_bank_switch_irq_timer
// Cartridge mapper with four 2 KB character banks, one switchable 16 KB
// program bank and a 16-bit down-counting IRQ timer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  item      in         item_valid / item_stall    func, address, value
//  result    out        result_valid / result_stall irq_line, rom_offset,
//                                                  mirror_mode, ram_write
//  config    in         APB (psel, penable, ...)   prg_bank_count, ram_present
//
// A transaction goes through the input register, then the result register.
// A new item is accepted every cycle while item_stall is low; the input
// register hands over to the result register whenever the latter is empty
// or being taken, so throughput is one item per cycle while nothing stalls.
// item_stall rises only when the input register holds an item and the
// result register is full and stalled. Reset is synchronous and active high;
// it empties both registers and returns the mapper state to its power-on
// values (banks 0..3, program bank 0, timer cleared, vertical mirroring).
//
module cartridge_bank_switch_irq_timer (
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  func,
  input  logic [15:0] address,
  input  logic [7:0]  value,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic        irq_line,
  output logic [17:0] rom_offset,
  output logic [1:0]  mirror_mode,
  output logic        ram_write,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. The register index is the word address.
  // --------------------------------------------------------------------------
  logic [4:0] prg_bank_count;
  logic       ram_present;
  logic       cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= cbsit_pkg::PRG_BANK_COUNT_RESET;
      ram_present    <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      if (cfg_index == cbsit_pkg::CFG_PRG_BANK_COUNT) begin
        prg_bank_count <= pwdata[4:0];
      end else begin
        ram_present <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (cfg_index == cbsit_pkg::CFG_PRG_BANK_COUNT) begin
      prdata = {27'd0, prg_bank_count};
    end else begin
      prdata = {31'd0, ram_present};
    end
  end

  // --------------------------------------------------------------------------
  // Input register.
  // --------------------------------------------------------------------------
  logic                 in_valid;
  cbsit_pkg::func_t     in_func;
  logic [15:0]          in_addr;
  logic [7:0]           in_value;
  logic                 out_free;
  logic                 advance;

  // The result register can take a new transaction when it is empty or its
  // current one leaves at this edge.
  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_valid && out_free;
  assign item_stall = in_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_func  <= item_valid ? func : in_func;
      in_addr  <= address;
      in_value <= value;
    end
  end

  // --------------------------------------------------------------------------
  // Mapper state.
  // --------------------------------------------------------------------------
  cbsit_pkg::chr_bank_t                  char_bank [4];
  cbsit_pkg::chr_bank_t                  char_bank_next [4];
  logic [cbsit_pkg::PRG_BANK_W-1:0]      prog_bank, prog_bank_next;
  logic [cbsit_pkg::COUNT_W-1:0]         irq_count, irq_count_next;
  logic                                  irq_enabled, irq_enabled_next;
  logic                                  low_byte_next, low_byte_next_next;
  logic                                  irq_pending, irq_pending_next;
  cbsit_pkg::mirror_t                    mirroring, mirroring_next;

  // Per-transaction result before the result register.
  cbsit_pkg::rom_ofs_t                   offset;
  logic                                  ramw;
  logic [cbsit_pkg::PRG_BANK_W-1:0]      bank_mask;
  cbsit_pkg::reg_sel_t                   reg_sel;
  logic [1:0]                            chr_slot;

  // The bank mask is the bank count minus one, kept to four bits; the fixed
  // upper window always maps to the masked last bank.
  assign bank_mask = 4'(prg_bank_count - 5'd1);
  assign reg_sel   = in_addr[14:12];
  assign chr_slot  = in_addr[12:11];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      char_bank_next[i] = char_bank[i];
    end
    prog_bank_next     = prog_bank;
    irq_count_next     = irq_count;
    irq_enabled_next   = irq_enabled;
    low_byte_next_next = low_byte_next;
    irq_pending_next   = irq_pending;
    mirroring_next     = mirroring;
    offset             = '0;
    ramw               = 1'b0;

    case (in_func)
      cbsit_pkg::FUNC_WRITE: begin
        if (in_addr[15:13] == 3'b011) begin
          // Work RAM window; flagged only when the RAM is fitted.
          ramw = ram_present;
        end else if (in_addr[15]) begin
          if (!in_addr[11]) begin
            // Writes with A11 clear acknowledge the interrupt.
            irq_pending_next = 1'b0;
          end else begin
            unique case (reg_sel)
              cbsit_pkg::SEL_CHR0: char_bank_next[0] = in_value[5:0];
              cbsit_pkg::SEL_CHR1: char_bank_next[1] = in_value[5:0];
              cbsit_pkg::SEL_CHR2: char_bank_next[2] = in_value[5:0];
              cbsit_pkg::SEL_CHR3: char_bank_next[3] = in_value[5:0];
              cbsit_pkg::SEL_COUNTER: begin
                // High byte first, then low byte, alternating.
                if (low_byte_next) begin
                  irq_count_next[7:0] = in_value;
                end else begin
                  irq_count_next[15:8] = in_value;
                end
                low_byte_next_next = !low_byte_next;
              end
              cbsit_pkg::SEL_ENABLE: begin
                irq_enabled_next   = in_value[4];
                low_byte_next_next = 1'b0;
              end
              cbsit_pkg::SEL_MIRROR: mirroring_next = in_value[1:0];
              cbsit_pkg::SEL_PRG:    prog_bank_next = in_value[3:0];
              default: ;
            endcase
          end
        end
      end
      cbsit_pkg::FUNC_TICK: begin
        // A counter already at zero stays there; only the step from one to
        // zero raises the interrupt.
        if (irq_enabled && (irq_count != '0)) begin
          irq_count_next = irq_count - 16'd1;
          if (irq_count == 16'd1) begin
            irq_pending_next = 1'b1;
          end
        end
      end
      cbsit_pkg::FUNC_PRG_LOOK: begin
        if (in_addr[15:14] == 2'b11) begin
          offset = {bank_mask, in_addr[13:0]};
        end else if (in_addr[15:14] == 2'b10) begin
          offset = {prog_bank & bank_mask, in_addr[13:0]};
        end
      end
      default: begin
        // Character lookup; nothing maps above the pattern tables.
        if (in_addr[15:13] == 3'b000) begin
          offset = 18'({char_bank[chr_slot], in_addr[cbsit_pkg::CHR_OFS_W-1:0]});
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        char_bank[i] <= cbsit_pkg::CHR_BANK_W'(i);
      end
      prog_bank     <= '0;
      irq_count     <= '0;
      irq_enabled   <= 1'b0;
      low_byte_next <= 1'b0;
      irq_pending   <= 1'b0;
      mirroring     <= cbsit_pkg::MIRROR_VERTICAL;
    end else if (advance) begin
      for (int i = 0; i < 4; i++) begin
        char_bank[i] <= char_bank_next[i];
      end
      prog_bank     <= prog_bank_next;
      irq_count     <= irq_count_next;
      irq_enabled   <= irq_enabled_next;
      low_byte_next <= low_byte_next_next;
      irq_pending   <= irq_pending_next;
      mirroring     <= mirroring_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. It reports the state left after the transaction.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      irq_line    <= irq_pending_next;
      rom_offset  <= offset;
      mirror_mode <= mirroring_next;
      ram_write   <= ramw;
    end
  end

endmodule

// File: src/cbsit_checker.sv
// ----------------------------------------------------------------------------
// cbsit_checker
// Port-level checks for the cartridge bank switch and IRQ timer block.
// ----------------------------------------------------------------------------
module cbsit_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [17:0] rom_offset,
  input logic        ram_write
);

  // A result held by a stall is still offered in the next cycle.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  // A RAM write never carries a ROM offset.
  a_ram_no_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && ram_write |-> rom_offset == 18'd0)
    else $error("RAM write result carries a ROM offset");

  // Reset empties the result register.
  a_reset_out_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Reset empties the input register, so the item side is open again.
  a_reset_in_open: assert property (@(posedge clk)
    rst |=> !item_stall)
    else $error("item stall right after reset");

endmodule

bind cartridge_bank_switch_irq_timer cbsit_checker u_cbsit_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .rom_offset   (rom_offset),
  .ram_write    (ram_write)
);
